FILE: rtl/mrc_pkg.sv
`timescale 1ns / 1ps
package mrc_pkg;
  localparam int unsigned HEADER_BYTES = 64;
  localparam int unsigned CHECKED_HEADER_BYTES = 52;
  localparam logic [31:0] VERSION_RESET = 32'd1;
  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [63:0] MAGIC = {8'h54, 8'h46, 8'h4E, 8'h4D, 8'h57, 8'h4F, 8'h4E, 8'h53};

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_TRUNCATED = 4'd1,
    ST_MAGIC     = 4'd2,
    ST_VERSION   = 4'd3,
    ST_RESERVED  = 4'd4,
    ST_HDRSIZE   = 4'd5,
    ST_ZEROCOUNT = 4'd6,
    ST_PAYLEN    = 4'd7,
    ST_FILELEN   = 4'd8,
    ST_HDRCRC    = 4'd9,
    ST_PAYCRC    = 4'd10,
    ST_ZEROGEN   = 4'd11,
    ST_ORDER     = 4'd12,
    ST_NEXTID    = 4'd13
  } status_t;

  typedef struct packed {
    logic        is_status;
    logic [63:0] seg_id;
    logic [3:0]  status;
    logic [63:0] generation;
    logic [63:0] next_id;
    logic [31:0] segment_count;
    logic        last_result;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction
endpackage

FILE: rtl/mrc_in_if.sv
`timescale 1ns / 1ps
interface mrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

FILE: rtl/mrc_out_if.sv
`timescale 1ns / 1ps
interface mrc_out_if;
  logic        valid;
  logic        ready;
  logic        is_status;
  logic [63:0] seg_id;
  logic [3:0]  status;
  logic [63:0] generation;
  logic [63:0] next_id;
  logic [31:0] segment_count;
  logic        last_result;
  modport source (output valid, is_status, seg_id, status, generation, next_id,
                  segment_count, last_result, input ready);
  modport sink (input valid, is_status, seg_id, status, generation, next_id,
                segment_count, last_result, output ready);
endinterface

FILE: rtl/mrc_cfg_if.sv
`timescale 1ns / 1ps
interface mrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/manifest_record_checker.sv
`timescale 1ns / 1ps
// Manifest record checker: checks a manifest streamed one byte per word, emitting each
// 64-bit segment id as it completes and one status word on the byte marked last. A byte
// is taken in any cycle in which the two-entry result buffer is empty or its only word
// leaves at that edge, so bytes that complete nothing flow one per cycle; the byte CRC-32C
// update and header capture sit between the input handshake and the result buffer, so a
// byte's results appear the cycle after it is accepted. A stalled output side stops input
// as soon as one result is waiting.
module manifest_record_checker (
  input  logic          clk,
  input  logic          rst_n,
  mrc_in_if.sink        in_ch,
  mrc_out_if.source     out_ch,
  mrc_cfg_if.sink       cfg_ch
);
  logic [31:0] ver_r;
  logic step, id_done, empty;
  mrc_pkg::result_t id_res, st_res, o;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) ver_r <= mrc_pkg::VERSION_RESET;
    else if (cfg_ch.valid) ver_r <= cfg_ch.data;
  end

  assign in_ch.ready = empty;
  assign step = in_ch.valid && in_ch.ready;

  mrc_core u_core (
    .clk, .rst_n, .step,
    .data_byte(in_ch.data_byte), .last_byte(in_ch.last_byte),
    .expected_version(ver_r), .id_done, .id_res, .st_res
  );

  mrc_out_buf u_buf (
    .clk, .rst_n,
    .push_a(step && id_done), .res_a(id_res),
    .push_b(step && in_ch.last_byte), .res_b(st_res),
    .empty, .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(o)
  );

  assign out_ch.is_status     = o.is_status;
  assign out_ch.seg_id        = o.seg_id;
  assign out_ch.status        = o.status;
  assign out_ch.generation    = o.generation;
  assign out_ch.next_id       = o.next_id;
  assign out_ch.segment_count = o.segment_count;
  assign out_ch.last_result   = o.last_result;
endmodule

FILE: rtl/mrc_core.sv
`timescale 1ns / 1ps
// stream state and checks; one byte per step, up to two results per byte
module mrc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [31:0]         expected_version,
  output logic                id_done,
  output mrc_pkg::result_t    id_res,
  output mrc_pkg::result_t    st_res
);
  logic [63:0] cnt_r, cnt_nxt;
  logic [31:0] crc_r, crc_nxt, snap_r, snap_nxt;
  logic [63:0] magic_r, gen_r, nid_r, paylen_r, rsvd_r, asm_r, prev_r;
  logic [63:0] magic_nxt, gen_nxt, nid_nxt, paylen_nxt, rsvd_nxt, asm_nxt, prev_nxt;
  logic [31:0] ver_r, flags_r, hsize_r, count_r, pcrc_r, hcrc_r;
  logic [31:0] ver_nxt, flags_nxt, hsize_nxt, count_nxt, pcrc_nxt, hcrc_nxt;
  logic        order_r, order_nxt;
  logic        in_hdr, sat;
  logic [5:0]  off;
  logic [2:0]  pos;
  logic [31:0] crc_upd;
  logic [63:0] b64, asm_val;
  mrc_pkg::status_t st;

  assign in_hdr  = (cnt_r[63:6] == 58'd0);
  assign sat     = &cnt_r;
  assign off     = cnt_r[5:0];
  assign pos     = sat ? 3'd0 : cnt_r[2:0];
  assign crc_upd = mrc_pkg::crc_byte(crc_r, data_byte);
  assign b64     = {56'd0, data_byte};
  assign asm_val = ((pos == 3'd0) && !sat ? 64'd0 : asm_r) | (b64 << {pos, 3'b000});

  // header field capture, byte lanes by offset
  function automatic logic [63:0] put64(input logic [63:0] v, input logic [5:0] o,
                                        input logic [5:0] base, input logic [7:0] b);
    logic [63:0] r;
    logic [5:0]  d;
    r = v;
    d = o - base;
    if (o >= base && d < 6'd8) r[{d[2:0], 3'b000} +: 8] = b;
    return r;
  endfunction

  function automatic logic [31:0] put32(input logic [31:0] v, input logic [5:0] o,
                                        input logic [5:0] base, input logic [7:0] b);
    logic [31:0] r;
    logic [5:0]  d;
    r = v;
    d = o - base;
    if (o >= base && d < 6'd4) r[{d[1:0], 3'b000} +: 8] = b;
    return r;
  endfunction

  always_comb begin
    st = mrc_pkg::ST_OK;
    if (cnt_nxt < 64'(mrc_pkg::HEADER_BYTES)) st = mrc_pkg::ST_TRUNCATED;
    else if (magic_nxt != mrc_pkg::MAGIC) st = mrc_pkg::ST_MAGIC;
    else if (ver_nxt != expected_version) st = mrc_pkg::ST_VERSION;
    else if (flags_nxt != 32'd0 || rsvd_nxt != 64'd0) st = mrc_pkg::ST_RESERVED;
    else if (hsize_nxt != 32'(mrc_pkg::HEADER_BYTES)) st = mrc_pkg::ST_HDRSIZE;
    else if (count_nxt == 32'd0) st = mrc_pkg::ST_ZEROCOUNT;
    else if (paylen_nxt != {29'd0, count_nxt, 3'd0}) st = mrc_pkg::ST_PAYLEN;
    else if (cnt_nxt - 64'(mrc_pkg::HEADER_BYTES) != paylen_nxt) st = mrc_pkg::ST_FILELEN;
    else if (hcrc_nxt != snap_nxt) st = mrc_pkg::ST_HDRCRC;
    else if (pcrc_nxt != ~crc_nxt) st = mrc_pkg::ST_PAYCRC;
    else if (gen_nxt == 64'd0) st = mrc_pkg::ST_ZEROGEN;
    else if (order_nxt) st = mrc_pkg::ST_ORDER;
    else if (nid_nxt <= prev_nxt) st = mrc_pkg::ST_NEXTID;
  end

  always_comb begin
    cnt_nxt = sat ? cnt_r : cnt_r + 64'd1;
    crc_nxt = crc_r; snap_nxt = snap_r;
    magic_nxt = magic_r; ver_nxt = ver_r; flags_nxt = flags_r; hsize_nxt = hsize_r;
    count_nxt = count_r; gen_nxt = gen_r; nid_nxt = nid_r; paylen_nxt = paylen_r;
    pcrc_nxt = pcrc_r; hcrc_nxt = hcrc_r; rsvd_nxt = rsvd_r;
    asm_nxt = asm_r; prev_nxt = prev_r; order_nxt = order_r;
    id_done = 1'b0;
    if (in_hdr) begin
      magic_nxt  = put64(magic_r, off, 6'd0, data_byte);
      ver_nxt    = put32(ver_r, off, 6'd8, data_byte);
      flags_nxt  = put32(flags_r, off, 6'd12, data_byte);
      hsize_nxt  = put32(hsize_r, off, 6'd16, data_byte);
      count_nxt  = put32(count_r, off, 6'd20, data_byte);
      gen_nxt    = put64(gen_r, off, 6'd24, data_byte);
      nid_nxt    = put64(nid_r, off, 6'd32, data_byte);
      paylen_nxt = put64(paylen_r, off, 6'd40, data_byte);
      pcrc_nxt   = put32(pcrc_r, off, 6'd48, data_byte);
      hcrc_nxt   = put32(hcrc_r, off, 6'd52, data_byte);
      rsvd_nxt   = put64(rsvd_r, off, 6'd56, data_byte);
      if (off < 6'(mrc_pkg::CHECKED_HEADER_BYTES)) begin
        crc_nxt = crc_upd;
        if (off == 6'(mrc_pkg::CHECKED_HEADER_BYTES - 1)) begin
          snap_nxt = ~crc_upd;
          crc_nxt  = '1;
        end
      end
    end else begin
      crc_nxt = crc_upd;
      asm_nxt = asm_val;
      if (pos == 3'd7 && !sat) begin
        id_done = 1'b1;
        if (asm_val <= prev_r) order_nxt = 1'b1;
        prev_nxt = asm_val;
      end
    end
  end

  always_comb begin
    id_res = '0;
    id_res.seg_id = asm_val;
    st_res = '0;
    st_res.is_status = 1'b1;
    st_res.status = st;
    st_res.generation = gen_nxt;
    st_res.next_id = nid_nxt;
    st_res.segment_count = count_nxt;
    st_res.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      cnt_r <= '0; crc_r <= '1; snap_r <= '0;
      magic_r <= '0; ver_r <= '0; flags_r <= '0; hsize_r <= '0; count_r <= '0;
      gen_r <= '0; nid_r <= '0; paylen_r <= '0; pcrc_r <= '0; hcrc_r <= '0;
      rsvd_r <= '0; asm_r <= '0; prev_r <= '0; order_r <= 1'b0;
    end else if (step) begin
      cnt_r <= cnt_nxt; crc_r <= crc_nxt; snap_r <= snap_nxt;
      magic_r <= magic_nxt; ver_r <= ver_nxt; flags_r <= flags_nxt;
      hsize_r <= hsize_nxt; count_r <= count_nxt; gen_r <= gen_nxt; nid_r <= nid_nxt;
      paylen_r <= paylen_nxt; pcrc_r <= pcrc_nxt; hcrc_r <= hcrc_nxt;
      rsvd_r <= rsvd_nxt; asm_r <= asm_nxt; prev_r <= prev_nxt; order_r <= order_nxt;
    end
  end
endmodule

FILE: rtl/mrc_out_buf.sv
`timescale 1ns / 1ps
// two-entry result fifo; takes up to two results per cycle when both entries free
module mrc_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_a,
  input  mrc_pkg::result_t res_a,
  input  logic             push_b,
  input  mrc_pkg::result_t res_b,
  output logic             empty,
  output logic             out_valid,
  input  logic             out_ready,
  output mrc_pkg::result_t out_res
);
  mrc_pkg::result_t e0_r, e1_r;
  logic [1:0] n_r, n_nxt;
  logic pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (n_r != 2'd0);
  assign out_res   = e0_r;
  assign empty     = (n_r == 2'd0) || (n_r == 2'd1 && pop);

  always_comb begin
    n_nxt = n_r - {1'b0, pop} + {1'b0, push_a} + {1'b0, push_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) n_r <= 2'd0;
    else n_r <= n_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop && n_r == 2'd2) e0_r <= e1_r;
    if (push_a && push_b) begin
      e0_r <= res_a;
      e1_r <= res_b;
    end else if (push_a || push_b) begin
      if (n_r == 2'd0 || (n_r == 2'd1 && pop)) e0_r <= push_a ? res_a : res_b;
      else e1_r <= push_a ? res_a : res_b;
    end
  end
endmodule

FILE: rtl/mrc_checker.sv
`timescale 1ns / 1ps
module mrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_status,
  input logic        out_last_result,
  input logic [63:0] out_seg_id,
  input logic [3:0]  out_status
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_seg_id)) else $error("hold");
  a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_status == out_last_result) else $error("last tag");
  a_id_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_status |-> out_status == 4'd0) else $error("id status");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_status |-> out_status <= 4'd13) else $error("range");
  // a byte is only taken while no result is stuck waiting
  a_in_gate: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready) else $error("in gate");
endmodule

bind manifest_record_checker mrc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_is_status(out_ch.is_status),
  .out_last_result(out_ch.last_result), .out_seg_id(out_ch.seg_id),
  .out_status(out_ch.status)
);
